// ----- src/tmcr_pkg.sv -----
// tmcr_pkg: shared types, constants and index helpers for the text-mode cell renderer
// no dependencies; used by every module of the renderer except tmcr_out_buf
package tmcr_pkg;

  localparam int unsigned SCREEN_DEPTH_DEF = 4096;
  localparam int unsigned GLYPH_DEPTH_DEF  = 8192;

  localparam int unsigned ADDR_W    = 14;
  localparam int unsigned OFFSET_W  = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned WRAP_W    = 18;
  localparam int unsigned WRAP_STEPS = 4;

  localparam logic [ADDR_W-1:0]   ADDRESS_MASK_RST   = 14'h0fff;
  localparam logic [ADDR_W-1:0]   CURSOR_ADDRESS_RST = 14'h0000;
  localparam logic [OFFSET_W-1:0] CHARSET_OFFSET_RST = 13'h0000;

  localparam logic [7:0] PIX_ALL_ONES = 8'hff;
  localparam logic [7:0] PIX_NONE     = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_OFFSET = 2'd2;

  typedef enum logic [1:0] {
    MODE_WR_SCREEN = 2'd0,
    MODE_WR_GLYPH  = 2'd1,
    MODE_DRAW      = 2'd2,
    MODE_BLANK     = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [3:0]        row;
    logic              reverse;
    logic              cursor_hit;
    logic [ADDR_W-1:0] address;
    logic [7:0]        write_data;
  } cell_ctl_t;

  // value modulo depth for value < 16 * depth, by conditional subtraction
  function automatic logic [ADDR_W-1:0] wrap_index(input logic [ADDR_W-1:0] value,
                                                   input int unsigned depth);
    logic [WRAP_W-1:0] rem;
    logic [WRAP_W-1:0] step;
    rem = WRAP_W'(value);
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      step = WRAP_W'(depth) << k;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[ADDR_W-1:0];
  endfunction

endpackage

// ----- src/tmcr_screen_stage.sv -----
// tmcr_screen_stage: first pipeline stage, screen RAM access and cursor compare
// depends on tmcr_pkg
module tmcr_screen_stage #(
  parameter int unsigned SCREEN_DEPTH = tmcr_pkg::SCREEN_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          accept_i,
  input  logic [1:0]                    mode_i,
  input  logic [tmcr_pkg::ADDR_W-1:0]   address_i,
  input  logic [7:0]                    write_data_i,
  input  logic [3:0]                    row_i,
  input  logic                          reverse_i,
  input  logic                          cursor_active_i,
  input  logic [tmcr_pkg::ADDR_W-1:0]   address_mask_i,
  input  logic [tmcr_pkg::ADDR_W-1:0]   cursor_address_i,
  output logic                          s1_valid_o,
  output tmcr_pkg::cell_ctl_t           s1_ctl_o,
  output logic [7:0]                    code_o
);

  localparam int unsigned IdxW = $clog2(SCREEN_DEPTH);

  logic [7:0] mem [SCREEN_DEPTH];

  tmcr_pkg::mode_e           mode;
  logic [tmcr_pkg::ADDR_W-1:0] saddr;
  logic [tmcr_pkg::ADDR_W-1:0] wr_wrap;
  logic [tmcr_pkg::ADDR_W-1:0] rd_wrap;
  logic [IdxW-1:0]           mem_idx;
  logic                      wr_en;
  logic                      rd_en;
  tmcr_pkg::cell_ctl_t       ctl_d;
  tmcr_pkg::cell_ctl_t       ctl_q;
  logic                      valid_q;
  logic [7:0]                code_q;

  assign mode    = tmcr_pkg::mode_e'(mode_i);
  assign saddr   = address_i & address_mask_i;
  assign wr_wrap = tmcr_pkg::wrap_index(address_i, SCREEN_DEPTH);
  assign rd_wrap = tmcr_pkg::wrap_index(saddr, SCREEN_DEPTH);
  assign wr_en   = accept_i && (mode == tmcr_pkg::MODE_WR_SCREEN);
  assign rd_en   = accept_i && (mode == tmcr_pkg::MODE_DRAW);
  assign mem_idx = wr_en ? wr_wrap[IdxW-1:0] : rd_wrap[IdxW-1:0];

  always_comb begin
    ctl_d            = ctl_q;
    ctl_d.mode       = mode;
    ctl_d.row        = row_i;
    ctl_d.reverse    = reverse_i;
    ctl_d.cursor_hit = cursor_active_i && (saddr == (cursor_address_i & address_mask_i));
    ctl_d.address    = address_i;
    ctl_d.write_data = write_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[mem_idx] <= write_data_i;
    end
    if (rd_en) begin
      code_q <= mem[mem_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= accept_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_ctl_o   = ctl_q;
  assign code_o     = code_q;

endmodule

// ----- src/tmcr_glyph_stage.sv -----
// tmcr_glyph_stage: second pipeline stage, glyph index and glyph RAM access
// depends on tmcr_pkg
module tmcr_glyph_stage #(
  parameter int unsigned GLYPH_DEPTH = tmcr_pkg::GLYPH_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          s1_valid_i,
  input  tmcr_pkg::cell_ctl_t           s1_ctl_i,
  input  logic [7:0]                    code_i,
  input  logic [tmcr_pkg::OFFSET_W-1:0] charset_offset_i,
  output logic                          s2_valid_o,
  output tmcr_pkg::cell_ctl_t           s2_ctl_o,
  output logic [7:0]                    glyph_o
);

  localparam int unsigned IdxW = $clog2(GLYPH_DEPTH);

  logic [7:0] mem [GLYPH_DEPTH];

  logic [tmcr_pkg::ADDR_W-1:0] gsum;
  logic [tmcr_pkg::ADDR_W-1:0] rd_wrap;
  logic [tmcr_pkg::ADDR_W-1:0] wr_wrap;
  logic [IdxW-1:0]             mem_idx;
  logic                        wr_en;
  logic                        rd_en;
  tmcr_pkg::cell_ctl_t         ctl_q;
  logic                        valid_q;
  logic [7:0]                  glyph_q;

  assign gsum    = {1'b0, charset_offset_i} + {2'b00, code_i, s1_ctl_i.row};
  assign rd_wrap = tmcr_pkg::wrap_index(gsum, GLYPH_DEPTH);
  assign wr_wrap = tmcr_pkg::wrap_index(s1_ctl_i.address, GLYPH_DEPTH);
  assign wr_en   = adv_i && s1_valid_i && (s1_ctl_i.mode == tmcr_pkg::MODE_WR_GLYPH);
  assign rd_en   = adv_i && s1_valid_i && (s1_ctl_i.mode == tmcr_pkg::MODE_DRAW);
  assign mem_idx = wr_en ? wr_wrap[IdxW-1:0] : rd_wrap[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[mem_idx] <= s1_ctl_i.write_data;
    end
    if (rd_en) begin
      glyph_q <= mem[mem_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_q <= s1_ctl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= s1_valid_i;
    end
  end

  assign s2_valid_o = valid_q;
  assign s2_ctl_o   = ctl_q;
  assign glyph_o    = glyph_q;

endmodule

// ----- src/tmcr_out_buf.sv -----
// tmcr_out_buf: output register with one skid entry
// depends on nothing but the clock and reset
module tmcr_out_buf (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  input  logic [7:0] res_pixels_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [7:0] pixels_o,
  output logic       skid_full_o
);

  logic       out_valid_q;
  logic       out_valid_d;
  logic [7:0] out_pix_q;
  logic [7:0] out_pix_d;
  logic       skid_valid_q;
  logic       skid_valid_d;
  logic [7:0] skid_pix_q;
  logic [7:0] skid_pix_d;
  logic       take;

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_pix_d    = out_pix_q;
    skid_valid_d = skid_valid_q;
    skid_pix_d   = skid_pix_q;
    if (skid_valid_q) begin
      if (take) begin
        out_pix_d    = skid_pix_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_pix_d   = res_pixels_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_pix_d   = res_pixels_i;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q  <= out_pix_d;
    skid_pix_q <= skid_pix_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixels_o    = out_pix_q;
  assign skid_full_o = skid_valid_q;

endmodule

// ----- src/text_mode_cell_renderer_core.sv -----
// text_mode_cell_renderer_core: top level of the text-mode cell renderer
// a draw or blank item passes the screen, glyph and output registers before its result shows
// one item per cycle unless stalled; screen RAM is read in stage one, glyph RAM in stage two
// ram writes give no result; a stalled result waits in a skid entry, then input stalls
// reset clears pipeline valids, output and skid, and sets the registers to their reset values
// screen and glyph RAM contents are not cleared by reset; depends on tmcr_pkg and submodules
module text_mode_cell_renderer_core #(
  parameter int unsigned SCREEN_DEPTH = tmcr_pkg::SCREEN_DEPTH_DEF,
  parameter int unsigned GLYPH_DEPTH  = tmcr_pkg::GLYPH_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tmcr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tmcr_pkg::ADDR_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [tmcr_pkg::ADDR_W-1:0]    address_i,
  input  logic [7:0]                     write_data_i,
  input  logic [3:0]                     row_i,
  input  logic                           reverse_i,
  input  logic                           cursor_active_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     pixels_o
);

  logic [tmcr_pkg::ADDR_W-1:0]   address_mask_q;
  logic [tmcr_pkg::ADDR_W-1:0]   cursor_address_q;
  logic [tmcr_pkg::OFFSET_W-1:0] charset_offset_q;

  logic                adv;
  logic                accept;
  logic                skid_full;
  logic                s1_valid;
  tmcr_pkg::cell_ctl_t s1_ctl;
  logic [7:0]          code;
  logic                s2_valid;
  tmcr_pkg::cell_ctl_t s2_ctl;
  logic [7:0]          glyph;
  logic                res_valid;
  logic [7:0]          res_pixels;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_mask_q   <= tmcr_pkg::ADDRESS_MASK_RST;
      cursor_address_q <= tmcr_pkg::CURSOR_ADDRESS_RST;
      charset_offset_q <= tmcr_pkg::CHARSET_OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tmcr_pkg::CFG_ADDRESS_MASK: begin
          address_mask_q <= cfg_data_i;
        end
        tmcr_pkg::CFG_CURSOR_ADDRESS: begin
          cursor_address_q <= cfg_data_i;
        end
        tmcr_pkg::CFG_CHARSET_OFFSET: begin
          charset_offset_q <= cfg_data_i[tmcr_pkg::OFFSET_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign adv        = !skid_full;
  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !skid_full;

  tmcr_screen_stage #(
    .SCREEN_DEPTH(SCREEN_DEPTH)
  ) u_screen (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .accept_i        (accept),
    .mode_i          (mode_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .row_i           (row_i),
    .reverse_i       (reverse_i),
    .cursor_active_i (cursor_active_i),
    .address_mask_i  (address_mask_q),
    .cursor_address_i(cursor_address_q),
    .s1_valid_o      (s1_valid),
    .s1_ctl_o        (s1_ctl),
    .code_o          (code)
  );

  tmcr_glyph_stage #(
    .GLYPH_DEPTH(GLYPH_DEPTH)
  ) u_glyph (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .s1_valid_i      (s1_valid),
    .s1_ctl_i        (s1_ctl),
    .code_i          (code),
    .charset_offset_i(charset_offset_q),
    .s2_valid_o      (s2_valid),
    .s2_ctl_o        (s2_ctl),
    .glyph_o         (glyph)
  );

  assign res_valid = s2_valid &&
                     ((s2_ctl.mode == tmcr_pkg::MODE_DRAW) ||
                      (s2_ctl.mode == tmcr_pkg::MODE_BLANK));

  always_comb begin
    res_pixels = glyph;
    if (s2_ctl.cursor_hit) begin
      res_pixels = res_pixels ^ tmcr_pkg::PIX_ALL_ONES;
    end
    if (s2_ctl.reverse) begin
      res_pixels = res_pixels ^ tmcr_pkg::PIX_ALL_ONES;
    end
    if (s2_ctl.mode == tmcr_pkg::MODE_BLANK) begin
      res_pixels = tmcr_pkg::PIX_NONE;
    end
  end

  tmcr_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_pixels_i(res_pixels),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .pixels_o    (pixels_o),
    .skid_full_o (skid_full)
  );

endmodule

// ----- src/tmcr_checker.sv -----
// tmcr_checker: port-level checks of the cell renderer, bound to the top level
// depends on tmcr_pkg and text_mode_cell_renderer_core
module tmcr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] mode_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] pixels_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixels_o))
    else $error("stalled result changed");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !in_stall_o)
    else $error("input still stalled after a result was taken");

  a_blank_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (mode_i == tmcr_pkg::MODE_BLANK) && !out_stall_i)
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o && (pixels_o == tmcr_pkg::PIX_NONE))
    else $error("blank item result missing or nonzero");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("result or stall visible during reset");

endmodule

bind text_mode_cell_renderer_core tmcr_checker u_tmcr_checker (.*);
